// File: rtl/lzfd_pkg.sv
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types and constants for the flag-word LZ decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

	localparam int unsigned ITEMS_PER_WORD = 30;
	localparam int unsigned FLAG_BYTES     = 4;
	localparam int unsigned LEN_SHIFT_BASE = 14;
	localparam int unsigned MIN_MATCH      = 3;
	localparam logic [13:0] DIST_FIELD_MASK = 14'h3fff;

	typedef struct packed {
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       done_res;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic read;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic start_copy;
		logic copy_end;
	} dp_status_t;

endpackage

// File: rtl/lzfd_if.sv
// ----------------------------------------------------------------------------
// lzfd_in_if / lzfd_out_if
// Valid/ready channels for packed input bytes and decompressed output bytes.
// ----------------------------------------------------------------------------
interface lzfd_in_if;
	logic               valid;
	logic               ready;
	lzfd_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lzfd_out_if;
	logic                valid;
	logic                ready;
	lzfd_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/lzfd_ctrl.sv
// ----------------------------------------------------------------------------
// lzfd_ctrl
// Controller state machine: input acceptance and match copy sequencing.
// ----------------------------------------------------------------------------
module lzfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lzfd_pkg::dp_status_t status,
	output lzfd_pkg::dp_cmd_t    cmd
);
	import lzfd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = status.slot_free;
				cmd.accept = in_valid && status.slot_free;
				if (cmd.accept && status.start_copy) begin
					state_d = ST_COPY_RD;
				end
			end
			ST_COPY_RD: begin
				cmd.read = 1'b1;
				state_d  = ST_COPY_EMIT;
			end
			ST_COPY_EMIT: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = status.copy_end ? ST_IDLE : ST_COPY_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/lzfd_datapath.sv
// ----------------------------------------------------------------------------
// lzfd_datapath
// Flag word decode, history memory, copy pointers, counters and output register.
// ----------------------------------------------------------------------------
module lzfd_datapath #(
	parameter int unsigned WINDOW_BYTES = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	input  lzfd_pkg::in_item_t   in_item,
	input  lzfd_pkg::dp_cmd_t    cmd,
	output lzfd_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzfd_pkg::out_item_t  out_item
);
	import lzfd_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam logic [AW:0] WIN_SIZE = (AW + 1)'(WINDOW_BYTES);
	localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_BYTES - 1);

	logic [7:0]    hist_mem [WINDOW_BYTES];
	logic [7:0]    rd_data_q;
	logic          rd_ok_q;

	logic [31:0]   out_size_q;
	logic [31:0]   flag_word_q;
	logic [4:0]    items_left_q;
	logic [2:0]    flag_bytes_q;
	logic          pair_pending_q;
	logic [7:0]    pair_high_q;
	logic [31:0]   bytes_written_q;
	logic          finished_q;
	logic [AW-1:0] wr_pos_q;
	logic          wrapped_q;
	logic [AW-1:0] rd_pos_q;
	logic [5:0]    len_q;
	logic          out_valid_q;
	out_item_t     out_item_q;

	logic          flag_bit;
	logic          active;
	logic          literal_go;
	logic          pair_go;
	logic [15:0]   pair;
	logic [1:0]    split;
	logic [14:0]   back_dist;
	logic [AW:0]   dist_ext;
	logic [AW:0]   wr_ext;
	logic [AW:0]   rd_start_ext;
	logic [5:0]    len_start;
	logic          emit_req;
	logic          emit_ok;
	logic [31:0]   bytes_inc;
	logic          done_now;
	logic [7:0]    emit_data;
	logic          emit_last;

	assign flag_bit   = flag_word_q[5'(items_left_q + 5'd1)];
	assign active     = cmd.accept && !finished_q && (items_left_q != '0);
	assign literal_go = active && !flag_bit;
	assign pair_go    = active && flag_bit && pair_pending_q;

	assign split     = flag_word_q[1:0];
	assign pair      = {pair_high_q, in_item.in_byte};
	assign back_dist = 15'(pair[13:0] & (DIST_FIELD_MASK >> split)) + 15'd1;
	assign len_start = 6'(pair >> (4'(LEN_SHIFT_BASE) - {2'b00, split})) + 6'(MIN_MATCH);
	assign dist_ext  = (AW + 1)'(back_dist);
	assign wr_ext    = {1'b0, wr_pos_q};

	always_comb begin
		if (wr_ext >= dist_ext) begin
			rd_start_ext = wr_ext - dist_ext;
		end else begin
			rd_start_ext = wr_ext + (WIN_SIZE - dist_ext);
		end
	end

	assign emit_req  = literal_go || cmd.emit;
	assign emit_ok   = !finished_q && (bytes_written_q < out_size_q);
	assign bytes_inc = bytes_written_q + 32'd1;
	assign done_now  = (bytes_inc == out_size_q);
	assign emit_data = literal_go ? in_item.in_byte : (rd_ok_q ? rd_data_q : 8'd0);
	assign emit_last = literal_go || (len_q == 6'd1) || done_now;

	assign status.slot_free  = !out_valid_q || out_ready;
	assign status.start_copy = !finished_q && (items_left_q != '0) && flag_bit
		&& pair_pending_q;
	assign status.copy_end   = !emit_ok || (len_q == 6'd1) || done_now;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (emit_req && emit_ok) begin
			hist_mem[wr_pos_q] <= emit_data;
		end
		if (cmd.read) begin
			rd_data_q <= hist_mem[rd_pos_q];
			rd_ok_q   <= wrapped_q || (rd_pos_q < wr_pos_q);
		end
		if (emit_req && emit_ok) begin
			out_item_q.out_byte    <= emit_data;
			out_item_q.last_of_run <= emit_last;
			out_item_q.done_res    <= done_now;
		end
		if (pair_go) begin
			rd_pos_q <= rd_start_ext[AW-1:0];
			len_q    <= len_start;
		end else if (cmd.emit) begin
			rd_pos_q <= (rd_pos_q == WIN_LAST) ? '0 : rd_pos_q + 1'b1;
			len_q    <= len_q - 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q      <= '0;
			flag_word_q     <= '0;
			items_left_q    <= '0;
			flag_bytes_q    <= '0;
			pair_pending_q  <= 1'b0;
			pair_high_q     <= '0;
			bytes_written_q <= '0;
			finished_q      <= 1'b0;
			wr_pos_q        <= '0;
			wrapped_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				out_size_q <= cfg_wdata;
			end
			if (cmd.accept && !finished_q) begin
				if (items_left_q == '0) begin
					flag_word_q <= {flag_word_q[23:0], in_item.in_byte};
					if (flag_bytes_q == 3'(FLAG_BYTES - 1)) begin
						flag_bytes_q <= '0;
						items_left_q <= 5'(ITEMS_PER_WORD);
					end else begin
						flag_bytes_q <= flag_bytes_q + 3'd1;
					end
				end else if (!flag_bit) begin
					items_left_q <= items_left_q - 5'd1;
				end else if (!pair_pending_q) begin
					pair_high_q    <= in_item.in_byte;
					pair_pending_q <= 1'b1;
				end else begin
					pair_pending_q <= 1'b0;
					items_left_q   <= items_left_q - 5'd1;
				end
			end
			if (emit_req) begin
				if (!emit_ok) begin
					finished_q <= 1'b1;
				end else begin
					bytes_written_q <= bytes_inc;
					if (done_now) begin
						finished_q <= 1'b1;
					end
					if (wr_pos_q == WIN_LAST) begin
						wr_pos_q  <= '0;
						wrapped_q <= 1'b1;
					end else begin
						wr_pos_q <= wr_pos_q + 1'b1;
					end
				end
			end
			if (emit_req && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/lz_flagword_decompressor.sv
// ----------------------------------------------------------------------------
// lz_flagword_decompressor
// Streaming flag-word LZ77 decompressor with a history window in block memory.
//
// Channel  Dir  Carries
// comp     in   in_byte: packed stream byte (flag word, literal or pair byte)
// decomp   out  out_byte, last_of_run, done_res: one decompressed byte
// cfg      in   cfg_we / cfg_wdata: output size register write
//
// Flag word bytes, the first pair byte and literals are taken in the idle state
// whenever the output register is free. After its second byte is taken, a match
// pair holds the input while each copied byte is read from the history memory
// (registered read) and then emitted. Reset needs no clearing pass; unwritten
// history entries read as zero. A stalled result holds the output register and
// blocks new transactions.
// ----------------------------------------------------------------------------
module lz_flagword_decompressor #(
	parameter int unsigned WINDOW_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	lzfd_in_if.sink     comp,
	lzfd_out_if.source  decomp
);
	import lzfd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	lzfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp.valid),
		.in_ready (comp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	lzfd_datapath #(
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (comp.payload),
		.cmd       (cmd),
		.status    (status),
		.out_valid (decomp.valid),
		.out_ready (decomp.ready),
		.out_item  (decomp.payload)
	);

endmodule

// File: rtl/lzfd_checker.sv
// ----------------------------------------------------------------------------
// lzfd_checker
// Port-level checks on the decompressor output and input transactions.
// ----------------------------------------------------------------------------
module lzfd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lzfd_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output valid dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("Output payload changed while stalled.");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> out_item.last_of_run)
		else $error("Final byte of the stream is not marked as last of run.");

	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.done_res |=> !out_valid)
		else $error("Output transaction after the unpacked size was reached.");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Input accepted while the output register is stalled.");

endmodule

bind lz_flagword_decompressor lzfd_checker u_lzfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (comp.ready),
	.out_valid (decomp.valid),
	.out_ready (decomp.ready),
	.out_item  (decomp.payload)
);
